// ===== sv/stg_pkg.sv =====
`timescale 1ns / 1ps

package stg_pkg;

    localparam int FREQ_W   = 13;
    localparam int GAIN_W   = 15;
    localparam int COUNT_W  = 7;
    localparam int SAMPLE_W = 16;
    localparam int ANGLE_W  = 16;
    localparam int MUL_W    = 17;
    localparam int PROD_W   = 2 * MUL_W;
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam int SAMPLE_RATE_HZ_DEF = 44100;
    localparam int BURST_FRAMES_DEF   = 64;
    localparam int PHASE_BITS_DEF     = 32;

    localparam logic [FREQ_W-1:0] FREQ_MIN   = 13'd20;
    localparam logic [FREQ_W-1:0] FREQ_MAX   = 13'd8000;
    localparam logic [FREQ_W-1:0] FREQ_RESET = 13'd440;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 15'd3277;

    localparam logic [MUL_W-1:0] SIN_A = 17'd102944;
    localparam logic [15:0]      SIN_B = 16'd42048;
    localparam logic [MUL_W-1:0] SIN_C = 17'd4640;

    localparam logic REG_FREQ = 1'b0;
    localparam logic REG_GAIN = 1'b1;

    typedef logic [3:0] t_op;

    localparam t_op OP_NOP   = 4'd0;
    localparam t_op OP_START = 4'd1;
    localparam t_op OP_DIV   = 4'd2;
    localparam t_op OP_PREP  = 4'd3;
    localparam t_op OP_T2    = 4'd4;
    localparam t_op OP_Y1    = 4'd5;
    localparam t_op OP_Y2    = 4'd6;
    localparam t_op OP_S     = 4'd7;
    localparam t_op OP_M     = 4'd8;
    localparam t_op OP_OUT   = 4'd9;
    localparam t_op OP_FIX   = 4'd10;

    typedef struct packed {
        logic in_valid;
        logic out_ready;
    } t_hs_in;

    typedef struct packed {
        logic in_ready;
        logic out_valid;
        logic out_last;
    } t_hs_out;

endpackage

// ===== sv/stg_regs.sv =====
`timescale 1ns / 1ps

module stg_regs import stg_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output logic [FREQ_W-1:0] o_freq,
    output logic [GAIN_W-1:0] o_gain
);

    logic [FREQ_W-1:0] r_freq;
    logic [GAIN_W-1:0] r_gain;
    logic [FREQ_W-1:0] n_freq;
    logic              w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_comb begin
        n_freq = pwdata[FREQ_W-1:0];
        if (n_freq < FREQ_MIN) begin
            n_freq = FREQ_MIN;
        end else if (n_freq > FREQ_MAX) begin
            n_freq = FREQ_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_freq <= FREQ_RESET;
            r_gain <= GAIN_RESET;
        end else if (w_wr) begin
            case (paddr[2])
                REG_FREQ: r_freq <= n_freq;
                REG_GAIN: r_gain <= pwdata[GAIN_W-1:0];
                default:  r_gain <= r_gain;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_FREQ: prdata = {{(APB_DW-FREQ_W){1'b0}}, r_freq};
            REG_GAIN: prdata = {{(APB_DW-GAIN_W){1'b0}}, r_gain};
            default:  prdata = '0;
        endcase
    end

    assign o_freq = r_freq;
    assign o_gain = r_gain;

endmodule

// ===== sv/stg_ctrl.sv =====
`timescale 1ns / 1ps

module stg_ctrl import stg_pkg::*; #(
    parameter int BURST_FRAMES = BURST_FRAMES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_hs_in             i_hs,
    input  logic [COUNT_W-1:0] i_frame_count,
    output t_hs_out            o_hs,
    output t_op                o_op
);

    localparam logic [COUNT_W-1:0] BURST_V = COUNT_W'(BURST_FRAMES);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_DIV  = 4'd1;
    localparam logic [3:0] S_PREP = 4'd2;
    localparam logic [3:0] S_T2   = 4'd3;
    localparam logic [3:0] S_Y1   = 4'd4;
    localparam logic [3:0] S_Y2   = 4'd5;
    localparam logic [3:0] S_S    = 4'd6;
    localparam logic [3:0] S_M    = 4'd7;
    localparam logic [3:0] S_OUT  = 4'd8;
    localparam logic [3:0] S_FIX  = 4'd9;

    logic [3:0]         r_state, n_state;
    logic [COUNT_W-1:0] r_left, n_left;
    logic               r_out_valid, n_out_valid;
    logic               r_out_last, n_out_last;
    logic [COUNT_W-1:0] w_count;
    logic               w_can_load;

    assign w_count    = (i_frame_count > BURST_V) ? BURST_V : i_frame_count;
    assign w_can_load = !r_out_valid || i_hs.out_ready;

    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        n_out_valid = r_out_valid;
        n_out_last  = r_out_last;
        o_op        = OP_NOP;
        if (r_out_valid && i_hs.out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_hs.in_valid && (w_count != '0)) begin
                    o_op    = OP_START;
                    n_left  = w_count;
                    n_state = S_DIV;
                end
            end
            S_DIV: begin
                o_op    = OP_DIV;
                n_state = S_FIX;
            end
            S_FIX: begin
                o_op    = OP_FIX;
                n_state = S_PREP;
            end
            S_PREP: begin
                o_op    = OP_PREP;
                n_state = S_T2;
            end
            S_T2: begin
                o_op    = OP_T2;
                n_state = S_Y1;
            end
            S_Y1: begin
                o_op    = OP_Y1;
                n_state = S_Y2;
            end
            S_Y2: begin
                o_op    = OP_Y2;
                n_state = S_S;
            end
            S_S: begin
                o_op    = OP_S;
                n_state = S_M;
            end
            S_M: begin
                o_op    = OP_M;
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_can_load) begin
                    o_op        = OP_OUT;
                    n_out_valid = 1'b1;
                    n_out_last  = (r_left == COUNT_W'(1));
                    n_left      = r_left - 1'b1;
                    n_state     = (r_left == COUNT_W'(1)) ? S_IDLE : S_PREP;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            r_out_last  <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_left      <= n_left;
            r_out_valid <= n_out_valid;
            r_out_last  <= n_out_last;
        end
    end

    assign o_hs.in_ready  = (r_state == S_IDLE);
    assign o_hs.out_valid = r_out_valid;
    assign o_hs.out_last  = r_out_last;

endmodule

// ===== sv/stg_datapath.sv =====
`timescale 1ns / 1ps

module stg_datapath import stg_pkg::*; #(
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF,
    parameter int PHASE_BITS     = PHASE_BITS_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_op                        i_op,
    input  logic [FREQ_W-1:0]          i_freq,
    input  logic [GAIN_W-1:0]          i_gain,
    output logic signed [SAMPLE_W-1:0] o_sample
);

    localparam int RW    = $clog2(SAMPLE_RATE_HZ);
    localparam int DW    = FREQ_W + PHASE_BITS;
    localparam int RCP_W = PHASE_BITS + FREQ_W + 1 - RW;
    localparam int EST_W = FREQ_W + RCP_W;
    localparam int BK_W  = RCP_W + RW + 1;
    localparam logic [RW:0] SR_V = (RW + 1)'(SAMPLE_RATE_HZ);
    localparam logic [63:0] RCP_FULL =
        (64'd1 << (PHASE_BITS + FREQ_W)) / 64'(SAMPLE_RATE_HZ);
    localparam logic [RCP_W-1:0] RCP = RCP_FULL[RCP_W-1:0];

    logic [PHASE_BITS-1:0] r_phase;
    logic [PHASE_BITS-1:0] r_inc;
    logic [DW-1:0]         r_dvd;
    logic [EST_W-1:0]      r_est;
    logic [RCP_W-1:0]      r_quo;
    logic [BK_W-1:0]       r_back;
    logic [14:0]           r_t;
    logic                  r_neg;
    logic [14:0]           r_t2;
    logic [MUL_W-1:0]      r_y;
    logic [MUL_W-1:0]      r_s;
    logic [14:0]           r_mag;
    logic [SAMPLE_W-1:0]   r_sample;

    logic [EST_W-1:0]   w_est;
    logic [RCP_W-1:0]   w_quo;
    logic [BK_W-1:0]    w_back;
    logic [BK_W-1:0]    w_rem;
    logic               w_ge;
    logic [ANGLE_W-1:0] w_angle;
    logic [14:0]        w_t;
    logic [MUL_W-1:0]   w_a;
    logic [MUL_W-1:0]   w_b;
    logic [PROD_W-1:0]  w_prod;

    // The reciprocal estimate of freq * 2^PHASE_BITS / rate is low by at most one.
    assign w_est  = EST_W'(i_freq) * EST_W'(RCP);
    assign w_quo  = r_est[EST_W-1 -: RCP_W];
    assign w_back = BK_W'(w_quo) * BK_W'(SR_V);
    assign w_rem  = {2'b00, r_dvd} - r_back;
    assign w_ge   = (w_rem >= BK_W'(SR_V));

    assign w_angle = r_phase[PHASE_BITS-1 -: ANGLE_W];
    assign w_t     = w_angle[14] ? (15'd16384 - {1'b0, w_angle[13:0]})
                                 : {1'b0, w_angle[13:0]};

    always_comb begin
        case (i_op)
            OP_T2: begin
                w_a = {2'b00, r_t};
                w_b = {2'b00, r_t};
            end
            OP_Y1: begin
                w_a = {2'b00, r_t2};
                w_b = SIN_C;
            end
            OP_Y2: begin
                w_a = {2'b00, r_t2};
                w_b = r_y;
            end
            OP_S: begin
                w_a = {2'b00, r_t};
                w_b = r_y;
            end
            OP_M: begin
                w_a = r_s;
                w_b = {2'b00, i_gain};
            end
            default: begin
                w_a = '0;
                w_b = '0;
            end
        endcase
    end

    assign w_prod = w_a * w_b;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
        end else if (i_op == OP_OUT) begin
            r_phase <= r_phase + r_inc;
        end
    end

    always_ff @(posedge i_clk) begin
        case (i_op)
            OP_START: begin
                r_dvd <= {i_freq, {PHASE_BITS{1'b0}}};
                r_est <= w_est;
            end
            OP_DIV: begin
                r_quo  <= w_quo;
                r_back <= w_back;
            end
            OP_FIX: begin
                r_inc <= PHASE_BITS'(r_quo + RCP_W'(w_ge));
            end
            OP_PREP: begin
                r_t   <= w_t;
                r_neg <= w_angle[15];
            end
            OP_T2: begin
                r_t2 <= w_prod[28:14];
            end
            OP_Y1: begin
                r_y <= {1'b0, SIN_B - w_prod[29:14]};
            end
            OP_Y2: begin
                r_y <= SIN_A - w_prod[30:14];
            end
            OP_S: begin
                r_s <= w_prod[31:15];
            end
            OP_M: begin
                r_mag <= w_prod[29:15];
            end
            OP_OUT: begin
                r_sample <= r_neg ? (16'd0 - {1'b0, r_mag}) : {1'b0, r_mag};
            end
            default: begin
                r_t <= r_t;
            end
        endcase
    end

    assign o_sample = r_sample;

endmodule

// ===== sv/sine_tone_generator.sv =====
`timescale 1ns / 1ps
// Channel        | Direction | Transaction content
// s_axis         | in        | tdata[6:0] frame_count, one burst request
// m_axis         | out       | tdata[15:0] left, [31:16] right, tlast on last frame
// APB            | in/out    | register 0 tone_frequency_hz, register 1 tone_gain
//
// A request is accepted in the idle state; the DIV and FIX states then form the phase
// increment by a reciprocal multiply and one correction step, and each frame runs PREP,
// T2, Y1, Y2, S, M and OUT on the shared multiplier. A zero count is taken and starts
// no burst; s_axis_tready is high only between bursts.
// A finished frame waits in the output register while the next one is computed; a stall
// on m_axis holds the sequencer only when the next frame is ready to be written.
// Reset is synchronous: phase clears to zero and the registers return to 440 Hz, 3277.

module sine_tone_generator import stg_pkg::*; #(
    parameter int SAMPLE_RATE_HZ = SAMPLE_RATE_HZ_DEF,
    parameter int BURST_FRAMES   = BURST_FRAMES_DEF,
    parameter int PHASE_BITS     = PHASE_BITS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [6:0] frame_count, [7] zero fill
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [31:0]       m_axis_tdata,   // [15:0] left_sample, [31:16] right_sample
    output logic              m_axis_tlast,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [APB_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready
);

    logic [FREQ_W-1:0]          w_freq;
    logic [GAIN_W-1:0]          w_gain;
    t_op                        w_op;
    t_hs_in                     w_hs_in;
    t_hs_out                    w_hs_out;
    logic signed [SAMPLE_W-1:0] w_sample;

    stg_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_freq  (w_freq),
        .o_gain  (w_gain)
    );

    assign w_hs_in.in_valid  = s_axis_tvalid;
    assign w_hs_in.out_ready = m_axis_tready;

    stg_ctrl #(
        .BURST_FRAMES (BURST_FRAMES)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_hs          (w_hs_in),
        .i_frame_count (s_axis_tdata[COUNT_W-1:0]),
        .o_hs          (w_hs_out),
        .o_op          (w_op)
    );

    stg_datapath #(
        .SAMPLE_RATE_HZ (SAMPLE_RATE_HZ),
        .PHASE_BITS     (PHASE_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_op     (w_op),
        .i_freq   (w_freq),
        .i_gain   (w_gain),
        .o_sample (w_sample)
    );

    assign s_axis_tready = w_hs_out.in_ready;
    assign m_axis_tvalid = w_hs_out.out_valid;
    assign m_axis_tlast  = w_hs_out.out_last;
    assign m_axis_tdata  = {w_sample, w_sample};

endmodule

// ===== sv/stg_checker.sv =====
`timescale 1ns / 1ps

module stg_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_s_tvalid,
    input logic        i_s_tready,
    input logic [7:0]  i_s_tdata,
    input logic        i_m_tvalid,
    input logic        i_m_tready,
    input logic [31:0] i_m_tdata,
    input logic        i_m_tlast,
    input logic        i_pready
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && !i_m_tready) |=>
            (i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast)))
        else $error("output changed while stalled");

    a_stereo_equal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[15:0] == i_m_tdata[31:16]))
        else $error("left and right samples differ");

    a_busy_after_request: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && i_s_tready && (i_s_tdata[6:0] != 7'd0)) |=> !i_s_tready)
        else $error("new request taken while a burst is running");

    a_no_request_mid_burst: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_m_tvalid && i_m_tready && !i_m_tlast) |-> !i_s_tready)
        else $error("ready for a request before the burst ended");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pready)
        else $error("register port not ready");

endmodule

bind sine_tone_generator stg_checker u_stg_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (s_axis_tvalid),
    .i_s_tready (s_axis_tready),
    .i_s_tdata  (s_axis_tdata),
    .i_m_tvalid (m_axis_tvalid),
    .i_m_tready (m_axis_tready),
    .i_m_tdata  (m_axis_tdata),
    .i_m_tlast  (m_axis_tlast),
    .i_pready   (pready)
);
